### hdl/lrgd_pkg.sv
// ----------------------------------------------------------------------------
// lrgd_pkg: shared types and constants
// Fixed-point widths, register codes and saturation helpers for the
// gradient descent regression block.
// ----------------------------------------------------------------------------
`default_nettype none
package lrgd_pkg;

	localparam int DATA_W = 32;
	localparam int WIDE_W = 64;
	localparam int REG_W  = 16;
	localparam int COST_W = 31;
	localparam int FRAC_W = 16;

	localparam logic [REG_W-1:0] LR_RESET   = 16'd655;
	localparam logic [REG_W-1:0] ITER_RESET = 16'd1500;

	localparam logic signed [DATA_W-1:0] ONE_Q16 = 32'sh0001_0000;
	localparam logic signed [WIDE_W-1:0] Q_MAX   = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [WIDE_W-1:0] Q_MIN   = -64'sh0000_0000_8000_0000;

	typedef enum logic {
		REG_LEARNING_RATE   = 1'b0,
		REG_ITERATION_COUNT = 1'b1
	} reg_index_t;

	function automatic logic sat32_hit(input logic signed [WIDE_W-1:0] v);
		return (v > Q_MAX) || (v < Q_MIN);
	endfunction

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > Q_MAX) begin
			r = Q_MAX[DATA_W-1:0];
		end else if (v < Q_MIN) begin
			r = Q_MIN[DATA_W-1:0];
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### hdl/lrgd_ram.sv
// ----------------------------------------------------------------------------
// lrgd_ram: generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none
module lrgd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### hdl/lrgd_div.sv
// ----------------------------------------------------------------------------
// lrgd_div: iterative unsigned divider
// Restoring division of a 64-bit dividend, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module lrgd_div #(
	parameter int DIV_W = 12
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [lrgd_pkg::WIDE_W-1:0]    dividend,
	input  wire logic [DIV_W-1:0]               divisor,
	output logic                                done,
	output logic [lrgd_pkg::WIDE_W-1:0]         quotient
);
	import lrgd_pkg::*;

	localparam int CNT_W = $clog2(WIDE_W);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dvs_q;
	logic [DIV_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quotient[WIDE_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WIDE_W - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quotient <= dividend;
			rem_q    <= '0;
			dvs_q    <= divisor;
		end else if (busy_q) begin
			rem_q    <= fits ? DIV_W'(trial - {1'b0, dvs_q}) : trial[DIV_W-1:0];
			quotient <= {quotient[WIDE_W-2:0], fits};
		end
	end
endmodule
`default_nettype wire

### hdl/linear_regression_gradient_descent.sv
// ----------------------------------------------------------------------------
// linear_regression_gradient_descent: batch gradient descent in Q16.16
// Loads (x, y) samples, trains intercept and slope once the last one is in and
// returns weights, cost and a prediction.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (low bit up)                        | tuser
//  s_axis   | in        | sample_x, sample_y, query_x               | -
//           |           | tlast = last_sample                       |
//  m_axis   | out       | intercept, slope, final_cost, prediction  | saturated
//  cfg      | in        | cfg_index 0 learning_rate, 1 iteration_count
//
//  A last word starts training; its run time for m samples is set by the
//  shared multiplier and the iterative divider (two divisions per pass, one
//  for the cost).
//  s_axis_tready is low through training and while the finished result waits
//  for the output register; samples of the next batch load while a word waits.
//  Reset clears control state only; the sample store needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module linear_regression_gradient_descent #(
	parameter int MAX_SAMPLES = 1024
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire logic [95:0]                  s_axis_tdata,  // sample_x, sample_y, query_x
	input  wire logic                         s_axis_tlast,  // last_sample
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	output logic [127:0]                      m_axis_tdata,  // intercept, slope, final_cost,
	                                                          // prediction, zero pad
	output logic                              m_axis_tuser,  // saturated
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_index,
	input  wire logic [lrgd_pkg::REG_W-1:0]   cfg_wdata
);
	import lrgd_pkg::*;

	localparam int AW    = $clog2(MAX_SAMPLES);
	localparam int CW    = AW + 1;
	localparam int DIV_W = CW + 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_MUL1, ST_ERR, ST_MUL2, ST_ACC, ST_DSET, ST_DIV,
		ST_SCL_LO, ST_SCL_HI, ST_UPD, ST_COST, ST_PMUL, ST_PRED, ST_DONE
	} state_t;

	state_t state_q;

	logic [REG_W-1:0]  lr_q, iter_q, it_q;
	logic [CW-1:0]     count_q, m_q, i_q;
	logic signed [DATA_W-1:0] t0_q, t1_q, x_q, y_q, err_q, query_q, pred_q;
	logic signed [WIDE_W-1:0] s0_q, s1_q, sq_q, p_q, mean_q;
	logic [COST_W-1:0] cost_q;
	logic              ovf_q, cost_pass_q, sel_q, neg_q, div_start_q;
	logic [WIDE_W-1:0] div_num_q;
	logic [DIV_W-1:0]  div_den_q;
	logic              div_done;
	logic [WIDE_W-1:0] quo;

	logic [2*DATA_W-1:0] ram_rdata;
	logic                store_we;
	logic                in_acc;

	logic signed [DATA_W:0]     mul_a, mul_b;
	logic signed [2*DATA_W+1:0] mul_p;
	logic signed [WIDE_W-1:0]   p_sh, err_w, upd_w, pred_w;
	logic signed [DATA_W-1:0]   t_sel;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign store_we = in_acc && (count_q < CW'(MAX_SAMPLES));
	assign s_axis_tready = (state_q == ST_IDLE);

	lrgd_ram #(.WIDTH(2*DATA_W), .DEPTH(MAX_SAMPLES)) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (count_q[AW-1:0]),
		.wdata (s_axis_tdata[63:0]),
		.raddr (i_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	lrgd_div #(.DIV_W(DIV_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_num_q),
		.divisor  (div_den_q),
		.done     (div_done),
		.quotient (quo)
	);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MUL1: begin
				mul_a = {t1_q[DATA_W-1], t1_q};
				mul_b = {ram_rdata[DATA_W-1], ram_rdata[DATA_W-1:0]};
			end
			ST_MUL2: begin
				mul_a = {err_q[DATA_W-1], err_q};
				mul_b = cost_pass_q ? {err_q[DATA_W-1], err_q} : {x_q[DATA_W-1], x_q};
			end
			ST_SCL_LO: begin
				mul_a = {1'b0, mean_q[DATA_W-1:0]};
				mul_b = {{(DATA_W+1-REG_W){1'b0}}, lr_q};
			end
			ST_SCL_HI: begin
				mul_a = {mean_q[WIDE_W-1], mean_q[WIDE_W-1:DATA_W]};
				mul_b = {{(DATA_W+1-REG_W){1'b0}}, lr_q};
			end
			ST_PMUL: begin
				mul_a = {t1_q[DATA_W-1], t1_q};
				mul_b = {query_q[DATA_W-1], query_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p  = mul_a * mul_b;
	assign p_sh   = p_q >>> FRAC_W;
	assign err_w  = WIDE_W'(t0_q) + p_sh - WIDE_W'(y_q);
	assign t_sel  = sel_q ? t1_q : t0_q;
	assign upd_w  = WIDE_W'(t_sel) - p_sh;
	assign pred_w = WIDE_W'(t0_q) + p_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			lr_q          <= LR_RESET;
			iter_q        <= ITER_RESET;
			count_q       <= '0;
			m_q           <= '0;
			i_q           <= '0;
			it_q          <= '0;
			t0_q          <= ONE_Q16;
			t1_q          <= ONE_Q16;
			ovf_q         <= 1'b0;
			cost_pass_q   <= 1'b0;
			sel_q         <= 1'b0;
			div_start_q   <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			// a finishing training reloads the output register itself
			if (m_axis_tvalid && m_axis_tready && state_q != ST_DONE) begin
				m_axis_tvalid <= 1'b0;
			end
			if (cfg_we) begin
				unique case (reg_index_t'(cfg_index))
					REG_LEARNING_RATE:   lr_q   <= cfg_wdata;
					REG_ITERATION_COUNT: iter_q <= cfg_wdata;
					default:             lr_q   <= lr_q;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_axis_tlast) begin
							m_q         <= store_we ? count_q + 1'b1 : count_q;
							count_q     <= '0;
							query_q     <= s_axis_tdata[95:64];
							t0_q        <= ONE_Q16;
							t1_q        <= ONE_Q16;
							ovf_q       <= 1'b0;
							it_q        <= '0;
							i_q         <= '0;
							s0_q        <= '0;
							s1_q        <= '0;
							sq_q        <= '0;
							sel_q       <= 1'b0;
							cost_pass_q <= (iter_q == '0);
							state_q     <= ST_RD;
						end else if (store_we) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				ST_RD: state_q <= ST_MUL1;
				ST_MUL1: begin
					x_q     <= ram_rdata[DATA_W-1:0];
					y_q     <= ram_rdata[2*DATA_W-1:DATA_W];
					p_q     <= mul_p[WIDE_W-1:0];
					state_q <= ST_ERR;
				end
				ST_ERR: begin
					err_q   <= sat32(err_w);
					ovf_q   <= ovf_q | sat32_hit(err_w);
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					p_q     <= mul_p[WIDE_W-1:0];
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (cost_pass_q) begin
						sq_q <= sq_q + p_sh;
					end else begin
						s0_q <= s0_q + WIDE_W'(err_q);
						s1_q <= s1_q + p_sh;
					end
					i_q     <= i_q + 1'b1;
					state_q <= (i_q + 1'b1 == m_q) ? ST_DSET : ST_RD;
				end
				ST_DSET: begin
					// pick the sum for this division; magnitude in, sign held
					if (cost_pass_q) begin
						div_num_q <= sq_q;
						neg_q     <= 1'b0;
						div_den_q <= {m_q, 1'b0};
					end else begin
						div_num_q <= sel_q ? (s1_q[WIDE_W-1] ? -s1_q : s1_q)
						                   : (s0_q[WIDE_W-1] ? -s0_q : s0_q);
						neg_q     <= sel_q ? s1_q[WIDE_W-1] : s0_q[WIDE_W-1];
						div_den_q <= {1'b0, m_q};
					end
					div_start_q <= 1'b1;
					state_q     <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						mean_q  <= neg_q ? -$signed(quo) : $signed(quo);
						state_q <= cost_pass_q ? ST_COST : ST_SCL_LO;
					end
				end
				ST_SCL_LO: begin
					p_q     <= mul_p[WIDE_W-1:0];
					state_q <= ST_SCL_HI;
				end
				ST_SCL_HI: begin
					p_q     <= p_q + {mul_p[DATA_W-1:0], {DATA_W{1'b0}}};
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					ovf_q <= ovf_q | sat32_hit(upd_w);
					i_q   <= '0;
					if (!sel_q) begin
						t0_q    <= sat32(upd_w);
						sel_q   <= 1'b1;
						state_q <= ST_DSET;
					end else begin
						t1_q    <= sat32(upd_w);
						sel_q   <= 1'b0;
						it_q    <= it_q + 1'b1;
						s0_q    <= '0;
						s1_q    <= '0;
						sq_q    <= '0;
						if (it_q + 1'b1 == iter_q) begin
							cost_pass_q <= 1'b1;
						end
						state_q <= ST_RD;
					end
				end
				ST_COST: begin
					if (mean_q > Q_MAX) begin
						cost_q <= {COST_W{1'b1}};
						ovf_q  <= 1'b1;
					end else begin
						cost_q <= mean_q[COST_W-1:0];
					end
					state_q <= ST_PMUL;
				end
				ST_PMUL: begin
					p_q     <= mul_p[WIDE_W-1:0];
					state_q <= ST_PRED;
				end
				ST_PRED: begin
					pred_q  <= sat32(pred_w);
					ovf_q   <= ovf_q | sat32_hit(pred_w);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tdata  <= {1'b0, pred_q, cost_q, t1_q, t0_q};
						m_axis_tuser  <= ovf_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### hdl/lrgd_checker.sv
// ----------------------------------------------------------------------------
// lrgd_checker: port-level checks
// Watches the stream ports of the regression block over time.
// ----------------------------------------------------------------------------
`default_nettype none
module lrgd_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic         s_axis_tlast,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [127:0] m_axis_tdata,
	input wire logic         m_axis_tuser
);
	// a last word starts training, so input must close next cycle
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input open after last word");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	// a result appears only at the end of training
	a_result_after_train: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result without training");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[127])
		else $error("pad bit set");
endmodule

bind linear_regression_gradient_descent lrgd_checker u_lrgd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
